>>> src/uod_pkg.sv
// ----------------------------------------------------------------------------
// uod_pkg
// Shared types and constants for the unwind opcode decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package uod_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    CMD_FINISH   = 4'd0,
    CMD_PUSH     = 4'd1,
    CMD_POP      = 4'd2,
    CMD_REGPOP   = 4'd3,
    CMD_REGTOSP  = 4'd4,
    CMD_VFPPOP   = 4'd5,
    CMD_WREGPOP  = 4'd6,
    CMD_WCGRPOP  = 4'd7,
    CMD_RESERVED = 4'd8,
    CMD_REFUSED  = 4'd9,
    CMD_TRUNC    = 4'd10
  } cmd_e;

  localparam logic [7:0] OP_FINISH  = 8'hb0;
  localparam logic [7:0] OP_LOWREGS = 8'hb1;
  localparam logic [7:0] OP_ULEB    = 8'hb2;
  localparam logic [7:0] OP_VFPX    = 8'hb3;
  localparam logic [7:0] OP_WREG    = 8'hc6;
  localparam logic [7:0] OP_WCGR    = 8'hc7;
  localparam logic [7:0] OP_VFP16   = 8'hc8;
  localparam logic [7:0] OP_VFPD    = 8'hc9;
  localparam logic [7:0] OP_RSV_A   = 8'h9d;
  localparam logic [7:0] OP_RSV_B   = 8'h9f;
  localparam logic [7:0] OP_REFUSE  = 8'h80;

  localparam int unsigned VFP_BANK16_BIT = 16;
  localparam int unsigned VFP_DOUBLE_BIT = 17;
  localparam int unsigned SP_REG_BIT     = 13;
  localparam logic [31:0] ULEB_POP_BASE  = 32'h0000_0204;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] data;
    logic        clr;   // offset restarts from zero before this command
    logic        stop;  // sequence ends with this command
  } uod_entry_t;

endpackage

`default_nettype wire

>>> src/uod_front.sv
// ----------------------------------------------------------------------------
// uod_front
// Byte gatherer: collects multi-byte opcodes and classifies each finished
// instruction into a command and data word.
// ----------------------------------------------------------------------------
`default_nettype none

module uod_front
  import uod_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] code_byte_i,
  input  wire logic       first_byte_i,
  input  wire logic       final_byte_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output uod_entry_t      q_entry_o
);

  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_REGMASK = 3'd1,
    K_LOWREGS = 3'd2,
    K_ULEB    = 3'd3,
    K_VFP     = 3'd4,
    K_WREG    = 3'd5,
    K_WCGR    = 3'd6
  } kind_e;

  kind_e       kind_q, kind_d;
  logic [7:0]  op_q, op_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  shift_q, shift_d;
  logic        halted_q, halted_d;
  logic        clr_q, clr_d;

  logic        accept;
  logic [8:0]  lowmask;
  logic [31:0] leb_bits;
  logic [31:0] acc_new;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign lowmask    = (9'd2 << code_byte_i[2:0]) - 9'd1;
  assign leb_bits   = {25'b0, code_byte_i[6:0]} << shift_q[4:0];

  always_comb begin
    kind_e       kind;
    logic        halted;
    logic        clr;
    logic        done;
    logic        stop;
    cmd_e        cmd;
    logic [31:0] data;
    logic [7:0]  b;

    b        = code_byte_i;
    kind     = first_byte_i ? K_NONE : kind_q;
    halted   = first_byte_i ? 1'b0 : halted_q;
    clr      = first_byte_i | clr_q;
    done     = 1'b1;
    stop     = 1'b0;
    cmd      = CMD_RESERVED;
    data     = '0;
    acc_new  = acc_q;
    shift_d  = shift_q;
    acc_d    = acc_q;
    op_d     = op_q;
    kind_d   = kind_q;
    halted_d = halted_q;
    clr_d    = clr_q;
    q_push_o = 1'b0;

    if (accept) begin
      kind_d   = kind;
      halted_d = halted;
      clr_d    = clr;
      if (first_byte_i) begin
        op_d    = '0;
        acc_d   = '0;
        shift_d = '0;
      end
    end

    if (accept && !halted) begin
      unique case (kind)
        K_NONE: begin
          op_d = b;
          if (b[7:6] == 2'b00) begin
            cmd  = CMD_POP;
            data = {24'b0, b[5:0], 2'b0} + 32'd4;
          end else if (b[7:6] == 2'b01) begin
            cmd  = CMD_PUSH;
            data = {24'b0, b[5:0], 2'b0} + 32'd4;
          end else if (b[7:4] == 4'h8) begin
            kind_d = K_REGMASK;
            done   = 1'b0;
          end else if (b[7:4] == 4'h9) begin
            if (b == OP_RSV_A || b == OP_RSV_B) begin
              cmd = CMD_RESERVED;
            end else begin
              cmd  = CMD_REGTOSP;
              data = {28'b0, b[3:0]};
            end
          end else if (b[7:4] == 4'ha) begin
            cmd  = CMD_REGPOP;
            data = {17'b0, b[3], 2'b0, lowmask[7:0], 4'b0};
          end else if (b == OP_FINISH) begin
            cmd = CMD_FINISH;
          end else if (b == OP_LOWREGS) begin
            kind_d = K_LOWREGS;
            done   = 1'b0;
          end else if (b == OP_ULEB) begin
            kind_d  = K_ULEB;
            done    = 1'b0;
            acc_d   = '0;
            shift_d = '0;
          end else if (b == OP_VFPX || b == OP_VFP16 || b == OP_VFPD) begin
            kind_d = K_VFP;
            done   = 1'b0;
          end else if (b[7:3] == 5'b10111) begin
            cmd  = CMD_VFPPOP;
            data = {24'b0, 5'b10000, b[2:0]};
          end else if (b[7:3] == 5'b11010) begin
            cmd  = CMD_VFPPOP;
            data = {24'b0, 5'b10000, b[2:0]};
            data[VFP_DOUBLE_BIT] = 1'b1;
          end else if (b[7:3] == 5'b11000 && b[2:0] <= 3'd5) begin
            cmd  = CMD_WREGPOP;
            data = {24'b0, 5'b10100, b[2:0]};
          end else if (b == OP_WREG) begin
            kind_d = K_WREG;
            done   = 1'b0;
          end else if (b == OP_WCGR) begin
            kind_d = K_WCGR;
            done   = 1'b0;
          end else begin
            cmd = CMD_RESERVED;
          end
        end
        K_REGMASK: begin
          if (op_q == OP_REFUSE && b == 8'h00) begin
            cmd = CMD_REFUSED;
          end else begin
            cmd  = CMD_REGPOP;
            data = {16'b0, op_q[3:0], b, 4'b0};
          end
        end
        K_LOWREGS, K_WCGR: begin
          if (b == 8'h00 || b[7:4] != 4'h0) begin
            cmd = CMD_RESERVED;
          end else begin
            cmd  = (kind == K_LOWREGS) ? CMD_REGPOP : CMD_WCGRPOP;
            data = {24'b0, b};
          end
        end
        K_ULEB: begin
          if (shift_q < 6'd32) begin
            acc_new = acc_q | leb_bits;
          end
          acc_d   = acc_new;
          shift_d = (shift_q > 6'd28) ? 6'd35 : shift_q + 6'd7;
          if (b[7]) begin
            done = 1'b0;
          end else begin
            cmd  = CMD_POP;
            data = {acc_new[29:0], 2'b0} + ULEB_POP_BASE;
          end
        end
        K_VFP: begin
          cmd  = CMD_VFPPOP;
          data = {24'b0, b};
          data[VFP_BANK16_BIT] = (op_q == OP_VFP16);
          data[VFP_DOUBLE_BIT] = (op_q != OP_VFPX);
        end
        K_WREG: begin
          cmd  = CMD_WREGPOP;
          data = {24'b0, b};
        end
        default: begin
          cmd = CMD_RESERVED;
        end
      endcase

      if (done || final_byte_i) begin
        if (!done) begin
          cmd  = CMD_TRUNC;
          data = '0;
        end
        case (cmd)
          CMD_FINISH, CMD_RESERVED, CMD_REFUSED, CMD_TRUNC: stop = 1'b1;
          default: stop = final_byte_i;
        endcase
        q_push_o = 1'b1;
        kind_d   = K_NONE;
        clr_d    = 1'b0;
        if (stop) begin
          halted_d = 1'b1;
          op_d     = '0;
          acc_d    = '0;
          shift_d  = '0;
        end
      end
    end

    q_entry_o.cmd  = cmd;
    q_entry_o.data = data;
    q_entry_o.clr  = clr;
    q_entry_o.stop = stop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= K_NONE;
      op_q     <= '0;
      acc_q    <= '0;
      shift_q  <= '0;
      halted_q <= 1'b1;
      clr_q    <= 1'b0;
    end else begin
      kind_q   <= kind_d;
      op_q     <= op_d;
      acc_q    <= acc_d;
      shift_q  <= shift_d;
      halted_q <= halted_d;
      clr_q    <= clr_d;
    end
  end

endmodule

`default_nettype wire

>>> src/uod_queue.sv
// ----------------------------------------------------------------------------
// uod_queue
// Short command FIFO between the byte gatherer and the offset tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module uod_queue
  import uod_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire uod_entry_t  entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output uod_entry_t       head_o
);

  uod_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> src/uod_back.sv
// ----------------------------------------------------------------------------
// uod_back
// Offset tracker: applies each command to the virtual SP offset and holds
// the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uod_back
  import uod_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire uod_entry_t  q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       command_o,
  output logic [31:0]      command_data_o,
  output logic signed [31:0] vsp_offset_o,
  output logic             sp_reload_o,
  output logic             sequence_end_o
);

  logic        out_valid_q, out_valid_d;
  logic [31:0] offset_q;
  logic [31:0] offset_d;
  logic [31:0] base;
  logic [31:0] delta;
  logic        spr;
  logic [4:0]  ones16;
  logic [2:0]  ones4;
  logic [31:0] regs8;

  logic [3:0]  cmd_q;
  logic [31:0] data_q;
  logic        spr_q;
  logic        stop_q;

  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign ones16      = 5'($countones(q_head_i.data[15:0]));
  assign ones4       = 3'($countones(q_head_i.data[3:0]));
  assign regs8       = {24'b0, ({1'b0, q_head_i.data[3:0]} + 5'd1), 3'b0};
  assign base        = q_head_i.clr ? '0 : offset_q;

  always_comb begin
    delta = '0;
    spr   = 1'b0;
    unique case (q_head_i.cmd)
      CMD_PUSH:    delta = -q_head_i.data;
      CMD_POP:     delta = q_head_i.data;
      CMD_REGPOP: begin
        delta = {25'b0, ones16, 2'b0};
        spr   = q_head_i.data[SP_REG_BIT];
      end
      CMD_REGTOSP: spr = 1'b1;
      CMD_VFPPOP: begin
        delta = regs8 + (q_head_i.data[VFP_DOUBLE_BIT] ? 32'd0 : 32'd4);
      end
      CMD_WREGPOP: delta = regs8;
      CMD_WCGRPOP: delta = {27'b0, ones4, 2'b0};
      default:     delta = '0;
    endcase
    offset_d = base + delta;
  end

  always_comb begin
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      offset_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        offset_q <= offset_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q  <= q_head_i.cmd;
      data_q <= q_head_i.data;
      spr_q  <= spr;
      stop_q <= q_head_i.stop;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_o      = cmd_q;
  assign command_data_o = data_q;
  assign vsp_offset_o   = offset_q;
  assign sp_reload_o    = spr_q;
  assign sequence_end_o = stop_q;

endmodule

`default_nettype wire

>>> src/unwind_opcode_decoder.sv
// A byte that completes an instruction is written to the command FIFO when it
// is accepted; the back end pops it into the output register once the output is free.
// Throughput: one byte per cycle; the two-entry command FIFO stalls the input
// only when it is full.
// Reset: parse state cleared, offset zero, decoder halted until a first byte.
// ----------------------------------------------------------------------------
// unwind_opcode_decoder
// ARM unwind opcode decoder with running virtual SP offset.
// ----------------------------------------------------------------------------
`default_nettype none

module unwind_opcode_decoder
  import uod_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         code_byte_i,
  input  wire logic               first_byte_i,
  input  wire logic               final_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [3:0]              command_o,
  output logic [31:0]             command_data_o,
  output logic signed [31:0]      vsp_offset_o,
  output logic                    sp_reload_o,
  output logic                    sequence_end_o
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  uod_entry_t q_entry;
  uod_entry_t q_head;

  uod_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_byte_i  (code_byte_i),
    .first_byte_i (first_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_entry)
  );

  uod_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  uod_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_o      (command_o),
    .command_data_o (command_data_o),
    .vsp_offset_o   (vsp_offset_o),
    .sp_reload_o    (sp_reload_o),
    .sequence_end_o (sequence_end_o)
  );

endmodule

`default_nettype wire

>>> tb/unwind_opcode_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unwind_opcode_decoder_tb
// Self-checking bench: a directed table of opcode bytes, then random unwind
// sequences and noise under several idle and stall mixes, scored against a
// local decoder model or, for typed table rows, their fixed expected results.
// ----------------------------------------------------------------------------

module unwind_opcode_decoder_tb;
  import uod_pkg::*;

  typedef enum logic [2:0] {
    PK_NONE, PK_REGMASK, PK_LOWREGS, PK_ULEB, PK_VFP, PK_WREG, PK_WCGR
  } pend_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] data;
    logic [31:0] vsp;
    logic        spr;
    logic        seq_end;
  } unwind_res_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        f;
    logic        l;
    logic        typed;
    unwind_res_t want;
  } dir_row_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [7:0]         code_byte_i    = 8'h00;
  logic               first_byte_i   = 1'b0;
  logic               final_byte_i   = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [3:0]         command_o;
  logic [31:0]        command_data_o;
  logic signed [31:0] vsp_offset_o;
  logic               sp_reload_o;
  logic               sequence_end_o;

  unwind_opcode_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_byte_i    (code_byte_i),
    .first_byte_i   (first_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_o      (command_o),
    .command_data_o (command_data_o),
    .vsp_offset_o   (vsp_offset_o),
    .sp_reload_o    (sp_reload_o),
    .sequence_end_o (sequence_end_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // decoder model state
  pend_e       pend_kind;
  logic [7:0]  held_op;
  logic [31:0] leb_acc;
  int          leb_sh;
  logic [31:0] vsp_acc;
  bit          halted;

  unwind_res_t expected_cmds[$];
  dir_row_t    dir_rows[$];
  logic [7:0]  instr_bytes[$];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_asks      = 0;
  int          hold_served    = 0;
  int          n_used         = 0;
  int          n_starts       = 0;
  int          n_checked      = 0;
  int          n_errors       = 0;
  logic [15:0] cmds_seen      = '0;

  function automatic int bit_count(logic [15:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 16; i++) n += v[i];
    return n;
  endfunction

  // Returns 1 if the byte was taken by the decoder (not ignored while halted).
  function automatic bit decode_byte(input logic [7:0] b, input bit f, input bit l,
                                     output bit produced, output unwind_res_t res);
    cmd_e        c;
    logic [31:0] d;
    bit          done;
    bit          spr;
    bit          stop;
    int          n;
    produced = 1'b0;
    res      = '0;
    if (f) begin
      pend_kind = PK_NONE;
      held_op   = '0;
      leb_acc   = '0;
      leb_sh    = 0;
      vsp_acc   = '0;
      halted    = 1'b0;
    end
    if (halted) return 1'b0;
    c    = CMD_RESERVED;
    d    = '0;
    done = 1'b1;
    spr  = 1'b0;
    stop = 1'b0;
    case (pend_kind)
      PK_NONE: begin
        if (b[7:6] == 2'b00) begin
          c = CMD_POP;
          d = {24'd0, b[5:0], 2'b00} + 32'd4;
        end else if (b[7:6] == 2'b01) begin
          c = CMD_PUSH;
          d = {24'd0, b[5:0], 2'b00} + 32'd4;
        end else if (b[7:4] == 4'h8) begin
          pend_kind = PK_REGMASK;
          done      = 1'b0;
        end else if (b[7:4] == 4'h9) begin
          if (b == OP_RSV_A || b == OP_RSV_B) begin
            c = CMD_RESERVED;
          end else begin
            c = CMD_REGTOSP;
            d = {28'd0, b[3:0]};
          end
        end else if (b[7:4] == 4'ha) begin
          n = b[2:0];
          c = CMD_REGPOP;
          d = ((32'd1 << (n + 1)) - 32'd1) << 4;
          if (b[3]) d[14] = 1'b1;
        end else if (b == OP_FINISH) begin
          c = CMD_FINISH;
        end else if (b == OP_LOWREGS) begin
          pend_kind = PK_LOWREGS;
          done      = 1'b0;
        end else if (b == OP_ULEB) begin
          pend_kind = PK_ULEB;
          done      = 1'b0;
          leb_acc   = '0;
          leb_sh    = 0;
        end else if (b == OP_VFPX || b == OP_VFP16 || b == OP_VFPD) begin
          pend_kind = PK_VFP;
          done      = 1'b0;
        end else if (b[7:3] == 5'b10111) begin
          c = CMD_VFPPOP;
          d = {24'd0, 5'b10000, b[2:0]};
        end else if (b[7:3] == 5'b11010) begin
          c = CMD_VFPPOP;
          d = {24'd0, 5'b10000, b[2:0]};
          d[VFP_DOUBLE_BIT] = 1'b1;
        end else if (b >= 8'hc0 && b <= 8'hc5) begin
          c = CMD_WREGPOP;
          d = {24'd0, 5'b10100, b[2:0]};
        end else if (b == OP_WREG) begin
          pend_kind = PK_WREG;
          done      = 1'b0;
        end else if (b == OP_WCGR) begin
          pend_kind = PK_WCGR;
          done      = 1'b0;
        end else begin
          c = CMD_RESERVED;
        end
        held_op = b;
      end
      PK_REGMASK: begin
        if (held_op == OP_REFUSE && b == 8'h00) begin
          c = CMD_REFUSED;
        end else begin
          c = CMD_REGPOP;
          d = {16'd0, held_op[3:0], b, 4'd0};
        end
      end
      PK_LOWREGS, PK_WCGR: begin
        if (b == 8'h00 || b[7:4] != 4'h0) begin
          c = CMD_RESERVED;
        end else begin
          c = (pend_kind == PK_LOWREGS) ? CMD_REGPOP : CMD_WCGRPOP;
          d = {24'd0, b};
        end
      end
      PK_ULEB: begin
        if (leb_sh < 32) leb_acc |= {25'd0, b[6:0]} << leb_sh;
        leb_sh = (leb_sh + 7 > 35) ? 35 : leb_sh + 7;
        if (b[7]) begin
          done = 1'b0;
        end else begin
          c = CMD_POP;
          d = leb_acc * 32'd4 + ULEB_POP_BASE;
        end
      end
      PK_VFP: begin
        c = CMD_VFPPOP;
        d = {24'd0, b};
        if (held_op == OP_VFP16) d[VFP_BANK16_BIT] = 1'b1;
        if (held_op != OP_VFPX) d[VFP_DOUBLE_BIT] = 1'b1;
      end
      default: begin
        c = CMD_WREGPOP;
        d = {24'd0, b};
      end
    endcase

    if (!done) begin
      if (!l) return 1'b1;
      c = CMD_TRUNC;
      d = '0;
    end

    case (c)
      CMD_PUSH: vsp_acc -= d;
      CMD_POP:  vsp_acc += d;
      CMD_REGPOP: begin
        vsp_acc += 32'd4 * bit_count(d[15:0]);
        spr      = d[SP_REG_BIT];
      end
      CMD_REGTOSP: spr = 1'b1;
      CMD_VFPPOP: begin
        vsp_acc += 32'd8 * ({28'd0, d[3:0]} + 32'd1);
        if (!d[VFP_DOUBLE_BIT]) vsp_acc += 32'd4;
      end
      CMD_WREGPOP: vsp_acc += 32'd8 * ({28'd0, d[3:0]} + 32'd1);
      CMD_WCGRPOP: vsp_acc += 32'd4 * bit_count({12'd0, d[3:0]});
      default: stop = 1'b1;
    endcase

    pend_kind = PK_NONE;
    if (l) stop = 1'b1;
    if (stop) begin
      held_op = '0;
      leb_acc = '0;
      leb_sh  = 0;
      halted  = 1'b1;
    end

    produced    = 1'b1;
    res.cmd     = c;
    res.data    = d;
    res.vsp     = vsp_acc;
    res.spr     = spr;
    res.seq_end = stop;
    return 1'b1;
  endfunction

  function automatic void plain_row(logic [7:0] b, bit f, bit l);
    dir_row_t r;
    r       = '0;
    r.b     = b;
    r.f     = f;
    r.l     = l;
    dir_rows.push_back(r);
  endfunction

  function automatic void typed_row(logic [7:0] b, bit f, bit l, cmd_e c,
                                    logic [31:0] d, logic [31:0] v, bit s, bit e);
    dir_row_t r;
    r              = '0;
    r.b            = b;
    r.f            = f;
    r.l            = l;
    r.typed        = 1'b1;
    r.want.cmd     = c;
    r.want.data    = d;
    r.want.vsp     = v;
    r.want.spr     = s;
    r.want.seq_end = e;
    dir_rows.push_back(r);
  endfunction

  task automatic send_req(input logic [7:0] b, input bit f, input bit l,
                          input bit typed, input unwind_res_t want);
    unwind_res_t res;
    bit          produced;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    code_byte_i  <= b;
    first_byte_i <= f;
    final_byte_i <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (decode_byte(b, f, l, produced, res)) begin
      n_used++;
      if (f) n_starts++;
    end
    if (produced) expected_cmds.push_back(typed ? want : res);
  endtask

  function automatic void build_instr();
    int         kind;
    int         n;
    logic [7:0] r;
    instr_bytes.delete();
    r    = 8'($urandom);
    kind = $urandom_range(0, 27);
    if (kind > 14) kind = kind % 13;
    case (kind)
      0: instr_bytes.push_back({2'b00, r[5:0]});
      1: instr_bytes.push_back({2'b01, r[5:0]});
      2: begin
        if ($urandom_range(0, 7) == 0) begin
          instr_bytes.push_back(OP_REFUSE);
          instr_bytes.push_back(8'h00);
        end else begin
          instr_bytes.push_back({4'h8, r[3:0]});
          instr_bytes.push_back(8'($urandom));
        end
      end
      3: instr_bytes.push_back({4'h9, r[3:0]});
      4: instr_bytes.push_back({4'ha, r[3:0]});
      5, 12: begin
        instr_bytes.push_back(kind == 5 ? OP_LOWREGS : OP_WCGR);
        if ($urandom_range(0, 3) == 0) instr_bytes.push_back(8'($urandom));
        else instr_bytes.push_back({4'h0, r[3:0]});
      end
      6: begin
        instr_bytes.push_back(OP_ULEB);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          r    = 8'($urandom);
          r[7] = (k != n - 1);
          instr_bytes.push_back(r);
        end
      end
      7: begin
        case ($urandom_range(0, 2))
          0:       instr_bytes.push_back(OP_VFPX);
          1:       instr_bytes.push_back(OP_VFP16);
          default: instr_bytes.push_back(OP_VFPD);
        endcase
        instr_bytes.push_back(8'($urandom));
      end
      8:  instr_bytes.push_back({5'b10111, r[2:0]});
      9:  instr_bytes.push_back({5'b11010, r[2:0]});
      10: instr_bytes.push_back(8'hc0 + 8'($urandom_range(0, 5)));
      11: begin
        instr_bytes.push_back(OP_WREG);
        instr_bytes.push_back(8'($urandom));
      end
      13: begin
        case ($urandom_range(0, 4))
          0:       instr_bytes.push_back(8'hb4 + 8'($urandom_range(0, 3)));
          1:       instr_bytes.push_back(8'hca + 8'($urandom_range(0, 5)));
          2:       instr_bytes.push_back(8'($urandom_range(8'hd8, 8'hff)));
          3:       instr_bytes.push_back(OP_RSV_A);
          default: instr_bytes.push_back(OP_RSV_B);
        endcase
      end
      default: instr_bytes.push_back(OP_FINISH);
    endcase
  endfunction

  // One unwind sequence: start flag on the first byte, then the last byte
  // flagged final, cut short (truncated), or left open.
  task automatic send_sequence();
    int nins;
    int mode;
    bit f;
    bit l;
    nins = $urandom_range(1, 8);
    mode = $urandom_range(0, 7);
    for (int i = 0; i < nins; i++) begin
      build_instr();
      if (i == nins - 1 && mode == 4 && instr_bytes.size() > 1)
        void'(instr_bytes.pop_back());
      for (int j = 0; j < instr_bytes.size(); j++) begin
        f = (i == 0 && j == 0);
        l = (i == nins - 1) && (j == instr_bytes.size() - 1) && (mode <= 4);
        send_req(instr_bytes[j], f, l, 1'b0, '0);
      end
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = n_used;
    while (n_used - start < n) begin
      if ($urandom_range(0, 9) < 8) begin
        send_sequence();
      end else begin
        send_req(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
                 1'b0, '0);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    n_errors++;
    $display("%0t: %s expected %h actual %h", $time, field, want, got);
  endtask

  // result side: stall pattern, long hold-off, and scoring
  initial begin
    int          hold_left;
    unwind_res_t want;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_cmds.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result cmd %h data %h", $time, command_o, command_data_o);
        end else begin
          want = expected_cmds.pop_front();
          n_checked++;
          cmds_seen[command_o] = 1'b1;
          if (command_o !== want.cmd) report("command", 32'(want.cmd), 32'(command_o));
          if (command_data_o !== want.data) report("command_data", want.data, command_data_o);
          if (vsp_offset_o !== want.vsp) report("vsp_offset", want.vsp, vsp_offset_o);
          if (sp_reload_o !== want.spr) report("sp_reload", 32'(want.spr), 32'(sp_reload_o));
          if (sequence_end_o !== want.seq_end)
            report("sequence_end", 32'(want.seq_end), 32'(sequence_end_o));
        end
      end
      if (hold_left == 0 && hold_served != hold_asks) begin
        hold_left = 300;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout: decoder results still outstanding");
    $display("unwind_opcode_decoder: mismatch");
    $finish;
  end

  initial begin
    pend_kind = PK_NONE;
    held_op   = '0;
    leb_acc   = '0;
    leb_sh    = 0;
    vsp_acc   = '0;
    halted    = 1'b1;

    plain_row(8'h05, 1'b0, 1'b0);  // ignored, decoder halted out of reset
    typed_row(OP_FINISH, 1'b1, 1'b0, CMD_FINISH, 32'h0, 32'h0, 1'b0, 1'b1);
    typed_row(8'h3f, 1'b1, 1'b0, CMD_POP, 32'h100, 32'h100, 1'b0, 1'b0);
    typed_row(8'h7f, 1'b0, 1'b0, CMD_PUSH, 32'h100, 32'h0, 1'b0, 1'b0);
    plain_row(OP_REFUSE, 1'b0, 1'b0);
    typed_row(8'h00, 1'b0, 1'b0, CMD_REFUSED, 32'h0, 32'h0, 1'b0, 1'b1);
    plain_row(8'h8f, 1'b1, 1'b0);
    plain_row(8'hff, 1'b0, 1'b0);  // full mask, SP reload
    plain_row(OP_RSV_A, 1'b0, 1'b0);
    plain_row(8'h95, 1'b1, 1'b0);  // vsp = r5
    plain_row(8'haf, 1'b0, 1'b0);
    plain_row(OP_LOWREGS, 1'b0, 1'b0);
    plain_row(8'h0f, 1'b0, 1'b0);
    plain_row(OP_ULEB, 1'b0, 1'b0);  // ULEB past 32 bits
    repeat (5) plain_row(8'hff, 1'b0, 1'b0);
    plain_row(8'h7f, 1'b0, 1'b0);
    plain_row(OP_VFPD, 1'b0, 1'b0);
    plain_row(8'hff, 1'b0, 1'b0);
    plain_row(OP_WREG, 1'b0, 1'b0);
    plain_row(8'hff, 1'b0, 1'b0);
    plain_row(OP_WCGR, 1'b0, 1'b0);
    plain_row(8'h0f, 1'b0, 1'b0);
    plain_row(8'hd7, 1'b0, 1'b1);  // complete instruction on the final byte
    typed_row(OP_VFP16, 1'b1, 1'b1, CMD_TRUNC, 32'h0, 32'h0, 1'b0, 1'b1);
    typed_row(8'hff, 1'b1, 1'b0, CMD_RESERVED, 32'h0, 32'h0, 1'b0, 1'b1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_req(dir_rows[i].b, dir_rows[i].f, dir_rows[i].l, dir_rows[i].typed,
               dir_rows[i].want);

    run_phase(0, 0, 140);
    run_phase(86, 0, 140);
    run_phase(0, 86, 140);
    run_phase(18, 18, 140);

    // back-pressure: receiver holds off while pops keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    hold_asks++;
    send_req(8'h00, 1'b1, 1'b0, 1'b0, '0);
    for (int i = 0; i < 30; i++)
      send_req({2'b00, 6'($urandom)}, 1'b0, i == 29, 1'b0, '0);

    wait_drained();
    repeat (12) @(posedge clk_i);

    $display("Sent %0d requests in %0d sequences, %0d results checked, %0d errors",
             n_used, n_starts, n_checked, n_errors);
    $display("Command codes returned: %b; idle/stall mixes 0/0 86/0 0/86 18/18 + hold-off",
             cmds_seen[10:0]);
    if (n_errors == 0) begin
      $display("unwind_opcode_decoder: match");
    end else begin
      $display("unwind_opcode_decoder: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
src/uod_pkg.sv
src/uod_front.sv
src/uod_queue.sv
src/uod_back.sv
src/unwind_opcode_decoder.sv
tb/unwind_opcode_decoder_tb.sv
